### hdl/upp_pkg.sv
package upp_pkg;

    localparam int CordicStepsDef = 16;
    localparam int CW = 50;
    localparam int ZW = 34;
    localparam logic signed [ZW-1:0] HalfPiA = 34'sd1686629712;
    localparam logic [31:0] InvGain = 32'd652032874;

    typedef enum logic [2:0] {
        REG_TARGET_X  = 3'd0,
        REG_TARGET_Y  = 3'd1,
        REG_TARGET_Z  = 3'd2,
        REG_TARGET_QZ = 3'd3,
        REG_GAIN_P    = 3'd4,
        REG_GAIN_I    = 3'd5,
        REG_GAIN_D    = 3'd6,
        REG_TOL       = 3'd7
    } t_reg;

    typedef enum logic [3:0] {
        S_IDLE, S_ERR, S_MUL, S_MWAIT, S_VSET, S_RSET, S_CORD, S_FIN
    } t_state;

    typedef enum logic [3:0] {
        OP_P, OP_I, OP_D, OP_WZ, OP_XY, OP_YY, OP_ZZ, OP_CX, OP_CY
    } t_op;

    typedef struct packed {
        logic        start;
        logic [33:0] a_mag;
        logic [31:0] b_mag;
    } t_mul_req;

    function automatic logic [31:0] sat32(input logic signed [CW-1:0] v);
        if (v > 50'sd2147483647) return 32'h7FFF_FFFF;
        if (v < -50'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic logic [47:0] sat48(input logic signed [CW-1:0] v);
        if (v > 50'sd140737488355327) return 48'h7FFF_FFFF_FFFF;
        if (v < -50'sd140737488355328) return 48'h8000_0000_0000;
        return v[47:0];
    endfunction

    function automatic logic [29:0] atan_tab(input logic [4:0] i);
        logic [29:0] r;
        unique case (i)
            5'd0:  r = 30'h3243F6A8;
            5'd1:  r = 30'h1DAC6705;
            5'd2:  r = 30'h0FADBAFC;
            5'd3:  r = 30'h07F56EA6;
            5'd4:  r = 30'h03FEAB76;
            5'd5:  r = 30'h01FFD55B;
            5'd6:  r = 30'h00FFFAAA;
            5'd7:  r = 30'h007FFF55;
            5'd8:  r = 30'h003FFFEA;
            5'd9:  r = 30'h001FFFFD;
            5'd10: r = 30'h000FFFFF;
            5'd11: r = 30'h0007FFFF;
            5'd12: r = 30'h0003FFFF;
            5'd13: r = 30'h0001FFFF;
            5'd14: r = 30'h0000FFFF;
            5'd15: r = 30'h00007FFF;
            5'd16: r = 30'h00003FFF;
            5'd17: r = 30'h00001FFF;
            5'd18: r = 30'h00000FFF;
            5'd19: r = 30'h000007FF;
            5'd20: r = 30'h000003FF;
            5'd21: r = 30'h000001FF;
            5'd22: r = 30'h000000FF;
            5'd23: r = 30'h0000007F;
            5'd24: r = 30'h0000003F;
            5'd25: r = 30'h0000001F;
            5'd26: r = 30'h0000000F;
            5'd27: r = 30'h00000007;
            5'd28: r = 30'h00000003;
            5'd29: r = 30'h00000001;
            default: r = 30'h0;
        endcase
        return r;
    endfunction

endpackage

### hdl/upp_pose_if.sv
interface upp_pose_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    modport source(output valid, pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z,
                   input ready);
    modport sink(input valid, pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z,
                 output ready);
endinterface

### hdl/upp_cmd_if.sv
interface upp_cmd_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] rate_yaw;
    logic               reached;
    modport source(output valid, vel_x, vel_y, vel_z, rate_yaw, reached, input ready);
    modport sink(input valid, vel_x, vel_y, vel_z, rate_yaw, reached, output ready);
endinterface

### hdl/upp_mul.sv
module upp_mul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  upp_pkg::t_mul_req i_req,
    output logic              o_done,
    output logic [65:0]       o_prod
);
    logic [33:0] r_a;
    logic [31:0] r_b;
    logic        r_ph;
    logic        r_busy;
    logic        r_done;
    logic [65:0] r_acc;
    logic [15:0] w_bh;
    logic [49:0] w_part;
    logic [65:0] w_add;

    assign w_bh   = r_ph ? r_b[31:16] : r_b[15:0];
    assign w_part = 50'(r_a) * 50'(w_bh);
    assign w_add  = r_ph ? {w_part, 16'b0} : {16'b0, w_part};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ph   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_ph   <= 1'b0;
            end else if (r_busy) begin
                r_ph <= 1'b1;
                if (r_ph) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a   <= i_req.a_mag;
            r_b   <= i_req.b_mag;
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= r_acc + w_add;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;
endmodule

### hdl/uav_pose_pid_body_frame.sv
// Four-axis PID pose controller with heading rotation into the body frame.
// i_pose carries one measured pose word (position Q16.16, quaternion Q1.14);
// o_cmd carries one command word per pose (velocities and yaw rate Q16.16,
// saturated, plus the sticky reached flag).
// Configuration: i_cfg_we writes i_cfg_wdata into register i_cfg_idx
// (targets, gains, tolerance); write only while the block is idle. A write
// to any target clears reached.
// Each pose takes eighteen multiplies through one shared 34x16 multiplier and
// two CORDIC passes, vectoring then rotation, of one iteration per cycle
// through one shift-add unit; when the heading vector is zero the vectoring
// pass is skipped. A new pose is accepted only once the previous one has
// finished, so poses are handled one at a time.
// The command sits in an output register; a new pose may be accepted while
// it waits, and the block holds at the end of that pose until o_cmd is taken.
// Reset (synchronous, active low) clears targets, integrals, last errors and
// reached, and loads the default gains and tolerance.
module uav_pose_pid_body_frame #(
    parameter int CORDIC_STEPS = upp_pkg::CordicStepsDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    upp_pose_if.sink    i_pose,
    upp_cmd_if.source   o_cmd,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_wdata
);
    localparam int ItW = $clog2(CORDIC_STEPS);
    localparam logic [ItW-1:0] ItLast = ItW'(CORDIC_STEPS - 1);
    localparam int CW = upp_pkg::CW;
    localparam int ZW = upp_pkg::ZW;

    upp_pkg::t_state n_state, r_state;
    upp_pkg::t_op    r_op;

    logic signed [31:0] r_tx, r_ty, r_tz;
    logic signed [15:0] r_tqz;
    logic [31:0]        r_gp, r_gi, r_gd;
    logic [30:0]        r_tol;

    logic signed [31:0] r_px, r_py, r_pz;
    logic signed [15:0] r_qw, r_qx, r_qy, r_qz;

    logic signed [31:0] r_err  [4];
    logic signed [31:0] r_last [4];
    logic signed [47:0] r_sum  [4];
    logic signed [31:0] r_u    [4];
    logic [1:0]         r_axis;
    logic signed [42:0] r_p;
    logic signed [31:0] r_t;
    logic signed [33:0] r_t3, r_t4;
    logic signed [ZW-1:0] r_yaw;

    logic signed [CW-1:0] r_cx, r_cy;
    logic signed [ZW-1:0] r_cz;
    logic [ItW-1:0]       r_it;
    logic                 r_vec;

    logic        r_reached;
    logic        r_ovalid;
    logic [31:0] r_ovx, r_ovy, r_ovz, r_oyaw;
    logic        r_oreached;

    upp_pkg::t_mul_req w_req;
    logic        w_done;
    logic [65:0] w_prod;

    logic signed [33:0] w_opa;
    logic signed [32:0] w_opb;
    logic               w_neg;
    logic signed [66:0] w_prod_s;
    logic signed [42:0] w_q;
    logic signed [CW-1:0] w_sum_new, w_u_new;
    logic signed [32:0] w_e [4];
    logic signed [16:0] w_dq;
    logic               w_all_in;
    logic signed [CW-1:0] w_xs, w_ys, w_nx, w_ny;
    logic signed [ZW-1:0] w_tab, w_nz, w_ang;
    logic               w_ccw;
    logic               w_load_out;
    logic signed [32:0] w_abs [4];

    upp_mul u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_req),
        .o_done (w_done),
        .o_prod (w_prod)
    );

    // operand select
    always_comb begin
        w_opa = '0;
        w_opb = '0;
        unique case (r_op)
            upp_pkg::OP_P:  begin w_opa = 34'(r_err[r_axis]); w_opb = {1'b0, r_gp}; end
            upp_pkg::OP_I:  begin w_opa = 34'(r_err[r_axis]); w_opb = {1'b0, r_gi}; end
            upp_pkg::OP_D:  begin
                w_opa = 34'(r_err[r_axis]) - 34'(r_last[r_axis]);
                w_opb = {1'b0, r_gd};
            end
            upp_pkg::OP_WZ: begin w_opa = 34'(r_qw); w_opb = 33'(r_qz); end
            upp_pkg::OP_XY: begin w_opa = 34'(r_qx); w_opb = 33'(r_qy); end
            upp_pkg::OP_YY: begin w_opa = 34'(r_qy); w_opb = 33'(r_qy); end
            upp_pkg::OP_ZZ: begin w_opa = 34'(r_qz); w_opb = 33'(r_qz); end
            upp_pkg::OP_CX: begin w_opa = 34'(r_u[0]); w_opb = {1'b0, upp_pkg::InvGain}; end
            upp_pkg::OP_CY: begin w_opa = 34'(r_u[1]); w_opb = {1'b0, upp_pkg::InvGain}; end
            default: ;
        endcase
    end

    assign w_neg       = w_opa[33] ^ w_opb[32];
    assign w_req.start = (r_state == upp_pkg::S_MUL);
    assign w_req.a_mag = w_opa[33] ? 34'(-w_opa) : 34'(w_opa);
    assign w_req.b_mag = w_opb[32] ? 32'(-w_opb) : 32'(w_opb);
    assign w_prod_s    = w_neg ? -$signed({1'b0, w_prod}) : $signed({1'b0, w_prod});
    assign w_q         = w_neg ? -$signed({1'b0, w_prod[65:24]})
                               : $signed({1'b0, w_prod[65:24]});
    assign w_sum_new   = CW'(r_sum[r_axis]) + CW'(w_q);
    assign w_u_new     = CW'(r_p) + CW'(r_sum[r_axis]) + CW'(w_q);

    // errors
    assign w_e[0] = 33'(r_tx) - 33'(r_px);
    assign w_e[1] = 33'(r_ty) - 33'(r_py);
    assign w_e[2] = 33'(r_tz) - 33'(r_pz);
    assign w_dq   = 17'(r_tqz) - 17'(r_qz);
    assign w_e[3] = 33'($signed({w_dq, 2'b00}));

    always_comb begin
        w_all_in = 1'b1;
        for (int k = 0; k < 4; k++) begin
            w_abs[k] = r_err[k][31] ? -33'(r_err[k]) : 33'(r_err[k]);
            if (!(w_abs[k] < $signed({2'b00, r_tol}))) w_all_in = 1'b0;
        end
    end

    // shared CORDIC iteration
    assign w_xs  = r_cx >>> r_it;
    assign w_ys  = r_cy >>> r_it;
    assign w_tab = ZW'(upp_pkg::atan_tab(5'(r_it)));
    assign w_ccw = r_vec ? !(r_cy > 0) : !r_cz[ZW-1];
    assign w_nx  = w_ccw ? r_cx - w_ys : r_cx + w_ys;
    assign w_ny  = w_ccw ? r_cy + w_xs : r_cy - w_xs;
    assign w_nz  = w_ccw ? r_cz - w_tab : r_cz + w_tab;
    assign w_ang = -r_yaw;

    assign w_load_out = (r_state == upp_pkg::S_FIN) && (!r_ovalid || o_cmd.ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            upp_pkg::S_IDLE:  if (i_pose.valid) n_state = upp_pkg::S_ERR;
            upp_pkg::S_ERR:   n_state = upp_pkg::S_MUL;
            upp_pkg::S_MUL:   n_state = upp_pkg::S_MWAIT;
            upp_pkg::S_MWAIT: begin
                if (w_done) begin
                    priority if (r_op == upp_pkg::OP_ZZ) n_state = upp_pkg::S_VSET;
                    else if (r_op == upp_pkg::OP_CY) n_state = upp_pkg::S_RSET;
                    else n_state = upp_pkg::S_MUL;
                end
            end
            upp_pkg::S_VSET:  n_state = (r_t3 == '0 && r_t4 == '0) ? upp_pkg::S_MUL
                                                                   : upp_pkg::S_CORD;
            upp_pkg::S_RSET:  n_state = upp_pkg::S_CORD;
            upp_pkg::S_CORD:  begin
                if (r_it == ItLast) n_state = r_vec ? upp_pkg::S_MUL : upp_pkg::S_FIN;
            end
            upp_pkg::S_FIN:   if (w_load_out) n_state = upp_pkg::S_IDLE;
            default:          n_state = upp_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= upp_pkg::S_IDLE;
        else          r_state <= n_state;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx <= '0; r_ty <= '0; r_tz <= '0; r_tqz <= '0;
            r_gp <= 32'd8388608; r_gi <= 32'd3355; r_gd <= 32'd839;
            r_tol <= 31'd32768;
            r_reached <= 1'b0;
            r_ovalid  <= 1'b0;
            for (int k = 0; k < 4; k++) begin
                r_last[k] <= '0;
                r_sum[k]  <= '0;
            end
        end else begin
            if (r_ovalid && o_cmd.ready) r_ovalid <= 1'b0;
            if (w_load_out) begin
                r_ovalid <= 1'b1;
                if (w_all_in) r_reached <= 1'b1;
            end
            if (r_state == upp_pkg::S_MWAIT && w_done) begin
                if (r_op == upp_pkg::OP_I) r_sum[r_axis] <= upp_pkg::sat48(w_sum_new);
                if (r_op == upp_pkg::OP_D) r_last[r_axis] <= r_err[r_axis];
            end
            if (i_cfg_we) begin
                unique case (upp_pkg::t_reg'(i_cfg_idx))
                    upp_pkg::REG_TARGET_X:  r_tx  <= i_cfg_wdata;
                    upp_pkg::REG_TARGET_Y:  r_ty  <= i_cfg_wdata;
                    upp_pkg::REG_TARGET_Z:  r_tz  <= i_cfg_wdata;
                    upp_pkg::REG_TARGET_QZ: r_tqz <= i_cfg_wdata[15:0];
                    upp_pkg::REG_GAIN_P:    r_gp  <= i_cfg_wdata;
                    upp_pkg::REG_GAIN_I:    r_gi  <= i_cfg_wdata;
                    upp_pkg::REG_GAIN_D:    r_gd  <= i_cfg_wdata;
                    upp_pkg::REG_TOL:       r_tol <= i_cfg_wdata[30:0];
                    default: ;
                endcase
                if (upp_pkg::t_reg'(i_cfg_idx) == upp_pkg::REG_TARGET_X ||
                    upp_pkg::t_reg'(i_cfg_idx) == upp_pkg::REG_TARGET_Y ||
                    upp_pkg::t_reg'(i_cfg_idx) == upp_pkg::REG_TARGET_Z ||
                    upp_pkg::t_reg'(i_cfg_idx) == upp_pkg::REG_TARGET_QZ)
                    r_reached <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            upp_pkg::S_IDLE: begin
                r_px <= i_pose.pos_x; r_py <= i_pose.pos_y; r_pz <= i_pose.pos_z;
                r_qw <= i_pose.quat_w; r_qx <= i_pose.quat_x;
                r_qy <= i_pose.quat_y; r_qz <= i_pose.quat_z;
            end
            upp_pkg::S_ERR: begin
                for (int k = 0; k < 4; k++) r_err[k] <= upp_pkg::sat32(CW'(w_e[k]));
                r_axis <= '0;
                r_op   <= upp_pkg::OP_P;
            end
            upp_pkg::S_MWAIT: begin
                if (w_done) begin
                    unique case (r_op)
                        upp_pkg::OP_P:  begin r_p <= w_q; r_op <= upp_pkg::OP_I; end
                        upp_pkg::OP_I:  r_op <= upp_pkg::OP_D;
                        upp_pkg::OP_D:  begin
                            r_u[r_axis] <= upp_pkg::sat32(w_u_new);
                            r_axis <= r_axis + 2'd1;
                            r_op <= (r_axis == 2'd3) ? upp_pkg::OP_WZ : upp_pkg::OP_P;
                        end
                        upp_pkg::OP_WZ: begin r_t <= w_prod_s[31:0]; r_op <= upp_pkg::OP_XY; end
                        upp_pkg::OP_XY: begin
                            r_t3 <= 34'({34'(r_t) + 34'($signed(w_prod_s[31:0])), 1'b0});
                            r_op <= upp_pkg::OP_YY;
                        end
                        upp_pkg::OP_YY: begin r_t <= w_prod_s[31:0]; r_op <= upp_pkg::OP_ZZ; end
                        upp_pkg::OP_ZZ: begin
                            r_t4 <= 34'sd268435456
                                  - 34'({34'(r_t) + 34'(w_prod_s[31:0]), 1'b0});
                        end
                        upp_pkg::OP_CX: begin
                            r_cx <= CW'(w_prod_s >>> 14);
                            r_op <= upp_pkg::OP_CY;
                        end
                        upp_pkg::OP_CY: r_cy <= CW'(w_prod_s >>> 14);
                        default: ;
                    endcase
                end
            end
            upp_pkg::S_VSET: begin
                r_vec <= 1'b1;
                r_it  <= '0;
                if (r_t3 == '0 && r_t4 == '0) begin
                    r_yaw <= '0;
                    r_op  <= upp_pkg::OP_CX;
                end else if (r_t4 < 0) begin
                    if (r_t3 >= 0) begin
                        r_cx <= CW'(r_t3); r_cy <= -CW'(r_t4); r_cz <= upp_pkg::HalfPiA;
                    end else begin
                        r_cx <= -CW'(r_t3); r_cy <= CW'(r_t4); r_cz <= -upp_pkg::HalfPiA;
                    end
                end else begin
                    r_cx <= CW'(r_t4); r_cy <= CW'(r_t3); r_cz <= '0;
                end
            end
            upp_pkg::S_RSET: begin
                r_vec <= 1'b0;
                r_it  <= '0;
                priority if (w_ang > upp_pkg::HalfPiA) begin
                    r_cx <= -r_cy; r_cy <= r_cx; r_cz <= w_ang - upp_pkg::HalfPiA;
                end else if (w_ang < -upp_pkg::HalfPiA) begin
                    r_cx <= r_cy; r_cy <= -r_cx; r_cz <= w_ang + upp_pkg::HalfPiA;
                end else begin
                    r_cz <= w_ang;
                end
            end
            upp_pkg::S_CORD: begin
                r_cx <= w_nx;
                r_cy <= w_ny;
                r_cz <= w_nz;
                r_it <= r_it + 1'b1;
                if (r_it == ItLast && r_vec) begin
                    r_yaw <= w_nz;
                    r_op  <= upp_pkg::OP_CX;
                end
            end
            upp_pkg::S_FIN: begin
                if (w_load_out) begin
                    r_ovx      <= upp_pkg::sat32(r_cx >>> 16);
                    r_ovy      <= upp_pkg::sat32(r_cy >>> 16);
                    r_ovz      <= r_u[2];
                    r_oyaw     <= r_u[3];
                    r_oreached <= r_reached | w_all_in;
                end
            end
            default: ;
        endcase
    end

    assign i_pose.ready   = (r_state == upp_pkg::S_IDLE);
    assign o_cmd.valid    = r_ovalid;
    assign o_cmd.vel_x    = r_ovx;
    assign o_cmd.vel_y    = r_ovy;
    assign o_cmd.vel_z    = r_ovz;
    assign o_cmd.rate_yaw = r_oyaw;
    assign o_cmd.reached  = r_oreached;

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> r_state == upp_pkg::S_MWAIT)
        else $error("multiplier result outside wait state");

    a_fin_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == upp_pkg::S_FIN && !r_ovalid) |=> r_ovalid)
        else $error("finished command not loaded into empty output register");

    a_target_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && (upp_pkg::t_reg'(i_cfg_idx) == upp_pkg::REG_TARGET_X ||
                      upp_pkg::t_reg'(i_cfg_idx) == upp_pkg::REG_TARGET_Y ||
                      upp_pkg::t_reg'(i_cfg_idx) == upp_pkg::REG_TARGET_Z ||
                      upp_pkg::t_reg'(i_cfg_idx) == upp_pkg::REG_TARGET_QZ))
        |=> !r_reached)
        else $error("target write did not clear reached");

    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pose.valid && i_pose.ready) |=> r_state == upp_pkg::S_ERR)
        else $error("accepted pose did not start error stage");
endmodule
